### rtl/core/iaid_pkg.sv
// Shared types and codes for the indexed array insert/delete block.
// No dependencies; imported by iaid_cell and indexed_array_insert_delete.
package iaid_pkg;

    // Fixed widths of the beat fields
    localparam int OP_W   = 3;
    localparam int IDX_W  = 6;
    localparam int CNT_W  = 7;
    localparam int VAL_W  = 32;
    localparam int SIZE_W = 7;
    localparam int ST_W   = 2;

    // Shift distances 1, 2, 4 .. 64: one per bit of a count
    localparam int STEP_N = CNT_W;

    // Common width used to move entries between the ports and the cells
    localparam int EXT_W = 64;

    // Operation codes
    localparam logic [OP_W-1:0] OP_WRITE  = 3'd0;
    localparam logic [OP_W-1:0] OP_READ   = 3'd1;
    localparam logic [OP_W-1:0] OP_DELETE = 3'd2;
    localparam logic [OP_W-1:0] OP_GAP    = 3'd3;
    localparam logic [OP_W-1:0] OP_RESIZE = 3'd4;

    // Status codes
    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
    localparam logic [ST_W-1:0] ST_ZERO  = 2'd2;

    // Command broadcast to every cell of the chain
    typedef struct packed {
        logic              wr;     // write the cell at lo
        logic              clr;    // zero cells at or above hi
        logic              shift;  // move cells in [lo, hi) by one distance
        logic              up;     // 1: open gap (take from below), 0: delete
        logic [STEP_N-1:0] step;   // one-hot distance
    } cell_cmd_t;

endpackage

### rtl/core/indexed_array_insert_delete.sv
// Indexed entry array with write, read, delete-range, open-gap and resize.
// Result: registered into the output register after decode; delete and gap first run
// one chain shift step per set bit of the shift distance (1 to 6 steps). in_stall holds
// off a new beat until the result is loaded, also while out_stall holds the output.
// Reset: all entries zero, fill level 0, capacity in use MAX_ENTRIES.
// Depends on iaid_pkg and iaid_cell.
module indexed_array_insert_delete
    import iaid_pkg::*;
#(
    parameter int MAX_ENTRIES = 64,
    parameter int ENTRY_WIDTH = 32
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [OP_W-1:0]   op,
    input  logic [IDX_W-1:0]  index,
    input  logic [CNT_W-1:0]  count,
    input  logic [VAL_W-1:0]  entry_value,
    input  logic [SIZE_W-1:0] requested_size,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [VAL_W-1:0]  read_value,
    output logic [ST_W-1:0]   status,
    output logic [SIZE_W-1:0] fill_level,
    output logic [SIZE_W-1:0] size_in_use
);

    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int XW = CW + 8;
    localparam int EW = ENTRY_WIDTH;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_DEC   = 2'd1;
    localparam logic [1:0] S_SHIFT = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [OP_W-1:0]   op_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [VAL_W-1:0]  val_reg;
    logic [SIZE_W-1:0] req_reg;
    logic [CW-1:0]     vc_reg, vc_next;
    logic [CW-1:0]     as_reg, as_next;
    logic [XW-1:0]     hi_reg, hi_next;
    logic              up_reg, up_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [ST_W-1:0]   st_reg, st_next;
    logic [VAL_W-1:0]  rd_reg, rd_next;

    logic              out_valid_reg, out_valid_next;
    logic [VAL_W-1:0]  rdv_out_reg;
    logic [ST_W-1:0]   st_out_reg;
    logic [SIZE_W-1:0] fill_out_reg;
    logic [SIZE_W-1:0] size_out_reg;

    logic              accept;
    logic              out_free;
    logic              load_out;

    // Cell chain
    logic [EW-1:0]     cell_q [MAX_ENTRIES];
    logic [EW-1:0]     rd_term [MAX_ENTRIES];
    logic [EW-1:0]     rd_or;
    cell_cmd_t         cmd;
    logic [XW-1:0]     lo_w;
    logic [XW-1:0]     hi_w;
    logic [EW-1:0]     wdata_w;
    logic [EXT_W-1:0]  val_ext;
    logic [EXT_W-1:0]  rd_ext;
    logic [CNT_W-1:0]  low_bit;

    // Decode terms
    logic [XW-1:0]     idx_x, cnt_x, vc_x, as_x, req_x;
    logic [XW-1:0]     del_n, gap_n, gap_top, req_sat, vc_cut;
    logic              acc_ok, rng_ok;
    logic [ST_W-1:0]   st_d;
    logic [VAL_W-1:0]  rd_d;
    logic [CW-1:0]     vc_d, as_d;
    logic              shift_d, up_d, wr_d, clr_d;
    logic [CNT_W-1:0]  n_d;
    logic [XW-1:0]     hi_d;

    assign accept   = in_valid && (state_reg == S_IDLE);
    assign in_stall = (state_reg != S_IDLE);
    assign out_free = !out_valid_reg || !out_stall;

    // Latch the input beat
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= op;
            idx_reg <= index;
            cnt_reg <= count;
            val_reg <= entry_value;
            req_reg <= requested_size;
        end
    end

    // Operation decode from the latched beat
    assign idx_x = XW'(idx_reg);
    assign cnt_x = XW'(cnt_reg);
    assign vc_x  = XW'(vc_reg);
    assign as_x  = XW'(as_reg);
    assign req_x = XW'(req_reg);

    assign acc_ok  = idx_x < as_x;
    assign rng_ok  = idx_x < vc_x;
    assign del_n   = (cnt_x < vc_x - idx_x) ? cnt_x : vc_x - idx_x;
    assign gap_n   = (cnt_x < as_x - idx_x) ? cnt_x : as_x - idx_x;
    assign gap_top = (vc_x + gap_n < as_x) ? vc_x + gap_n : as_x;
    assign req_sat = (req_x == '0) ? XW'(1)
                   : ((req_x > XW'(MAX_ENTRIES)) ? XW'(MAX_ENTRIES) : req_x);
    assign vc_cut  = (vc_x < req_sat) ? vc_x : req_sat;

    assign rd_ext = EXT_W'(rd_or);

    always_comb
    begin
        st_d    = ST_OK;
        rd_d    = '0;
        vc_d    = vc_reg;
        as_d    = as_reg;
        shift_d = 1'b0;
        up_d    = 1'b0;
        wr_d    = 1'b0;
        clr_d   = 1'b0;
        n_d     = '0;
        hi_d    = vc_x;
        case (op_reg)
            OP_WRITE:
            begin
                if (acc_ok)
                    wr_d = 1'b1;
                else
                    st_d = ST_RANGE;
            end
            OP_READ:
            begin
                if (acc_ok)
                    rd_d = rd_ext[VAL_W-1:0];
                else
                    st_d = ST_RANGE;
            end
            OP_DELETE:
            begin
                if (cnt_reg == '0)
                    st_d = ST_ZERO;
                else if (!rng_ok)
                    st_d = ST_RANGE;
                else
                begin
                    shift_d = 1'b1;
                    n_d     = CNT_W'(del_n);
                    hi_d    = vc_x;
                    vc_d    = CW'(vc_x - del_n);
                end
            end
            OP_GAP:
            begin
                if (cnt_reg == '0)
                    st_d = ST_ZERO;
                else if (!rng_ok)
                    st_d = ST_RANGE;
                else
                begin
                    shift_d = 1'b1;
                    up_d    = 1'b1;
                    n_d     = CNT_W'(gap_n);
                    hi_d    = gap_top;
                    vc_d    = CW'(gap_top);
                end
            end
            OP_RESIZE:
            begin
                clr_d = 1'b1;
                hi_d  = vc_cut;
                as_d  = CW'(req_sat);
                vc_d  = CW'(vc_cut);
            end
            default:
            begin
                st_d = ST_OK;
            end
        endcase
    end

    // Cell command
    assign low_bit = rem_reg & (~rem_reg + CNT_W'(1));
    assign lo_w    = idx_x;
    assign hi_w    = (state_reg == S_DEC) ? hi_d : hi_reg;
    assign val_ext = EXT_W'(val_reg);
    assign wdata_w = val_ext[EW-1:0];

    always_comb
    begin
        cmd       = '0;
        cmd.up    = up_reg;
        if (state_reg == S_DEC)
        begin
            cmd.wr  = wr_d;
            cmd.clr = clr_d;
        end
        else if (state_reg == S_SHIFT)
        begin
            cmd.shift = 1'b1;
            cmd.step  = low_bit;
        end
    end

    // Control sequencer
    always_comb
    begin
        state_next = state_reg;
        vc_next    = vc_reg;
        as_next    = as_reg;
        hi_next    = hi_reg;
        up_next    = up_reg;
        rem_next   = rem_reg;
        st_next    = st_reg;
        rd_next    = rd_reg;
        load_out   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    state_next = S_DEC;
            end
            S_DEC:
            begin
                vc_next = vc_d;
                as_next = as_d;
                st_next = st_d;
                rd_next = rd_d;
                if (shift_d)
                begin
                    hi_next    = hi_d;
                    up_next    = up_d;
                    rem_next   = n_d;
                    state_next = S_SHIFT;
                end
                else if (out_free)
                begin
                    load_out   = 1'b1;
                    state_next = S_IDLE;
                end
                else
                    state_next = S_DONE;
            end
            S_SHIFT:
            begin
                rem_next = rem_reg & ~low_bit;
                if (rem_next == '0)
                begin
                    if (out_free)
                    begin
                        load_out   = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                        state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    load_out   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            vc_reg    <= '0;
            as_reg    <= CW'(MAX_ENTRIES);
            rem_reg   <= '0;
            up_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            vc_reg    <= vc_next;
            as_reg    <= as_next;
            rem_reg   <= rem_next;
            up_reg    <= up_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hi_reg <= hi_next;
        st_reg <= st_next;
        rd_reg <= rd_next;
    end

    // Output register
    assign out_valid_next = load_out ? 1'b1 : (out_stall ? out_valid_reg : 1'b0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            rdv_out_reg  <= rd_next;
            st_out_reg   <= st_next;
            fill_out_reg <= SIZE_W'(vc_next);
            size_out_reg <= SIZE_W'(as_next);
        end
    end

    assign out_valid   = out_valid_reg;
    assign read_value  = rdv_out_reg;
    assign status      = st_out_reg;
    assign fill_level  = fill_out_reg;
    assign size_in_use = size_out_reg;

    // Read select across the chain
    always_comb
    begin
        rd_or = '0;
        for (int i = 0; i < MAX_ENTRIES; i++)
            rd_or = rd_or | rd_term[i];
    end

    // Chain of cells with neighbor taps at power-of-two distances
    for (genvar gi = 0; gi < MAX_ENTRIES; gi++)
    begin : g_cell
        logic [STEP_N-1:0][EW-1:0] up_w;
        logic [STEP_N-1:0][EW-1:0] dn_w;

        for (genvar gk = 0; gk < STEP_N; gk++)
        begin : g_nb
            if (gi + (1 << gk) < MAX_ENTRIES)
            begin : g_up
                assign up_w[gk] = cell_q[gi + (1 << gk)];
            end
            else
            begin : g_up0
                assign up_w[gk] = '0;
            end
            if (gi >= (1 << gk))
            begin : g_dn
                assign dn_w[gk] = cell_q[gi - (1 << gk)];
            end
            else
            begin : g_dn0
                assign dn_w[gk] = '0;
            end
        end

        iaid_cell #(
            .IDX (gi),
            .XW  (XW),
            .EW  (EW)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .cmd     (cmd),
            .lo      (lo_w),
            .hi      (hi_w),
            .wdata   (wdata_w),
            .nbr_up  (up_w),
            .nbr_dn  (dn_w),
            .q       (cell_q[gi]),
            .rd_term (rd_term[gi])
        );
    end

endmodule

### rtl/core/iaid_cell.sv
// One storage cell of the entry chain: holds one entry and takes a new
// value from itself, a neighbor at a power-of-two distance, write data or zero.
// Depends on iaid_pkg.
module iaid_cell
    import iaid_pkg::*;
#(
    parameter int IDX = 0,
    parameter int XW  = 19,
    parameter int EW  = 32
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  cell_cmd_t                 cmd,
    input  logic [XW-1:0]             lo,
    input  logic [XW-1:0]             hi,
    input  logic [EW-1:0]             wdata,
    input  logic [STEP_N-1:0][EW-1:0] nbr_up,
    input  logic [STEP_N-1:0][EW-1:0] nbr_dn,
    output logic [EW-1:0]             q,
    output logic [EW-1:0]             rd_term
);

    localparam logic [XW-1:0] MY = XW'(IDX);

    logic [EW-1:0] data_reg;
    logic [EW-1:0] data_next;
    logic [EW-1:0] shift_val;
    logic          in_rng;

    // Source for a shift step; out-of-region sources read as zero
    always_comb
    begin
        shift_val = '0;
        for (int k = 0; k < STEP_N; k++)
        begin
            if (cmd.step[k])
            begin
                if (cmd.up)
                begin
                    if (MY >= lo + (XW'(1) << k))
                        shift_val = nbr_dn[k];
                end
                else
                begin
                    if (MY + (XW'(1) << k) < hi)
                        shift_val = nbr_up[k];
                end
            end
        end
    end

    assign in_rng = (MY >= lo) && (MY < hi);

    // Next value select
    always_comb
    begin
        data_next = data_reg;
        if (cmd.wr && (MY == lo))
            data_next = wdata;
        else if (cmd.clr && (MY >= hi))
            data_next = '0;
        else if (cmd.shift && in_rng)
            data_next = shift_val;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            data_reg <= '0;
        else
            data_reg <= data_next;
    end

    assign q       = data_reg;
    assign rd_term = (MY == lo) ? data_reg : '0;

endmodule
